### rtl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property every clock outside of reset.
`define PP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds outside of reset.
`define PP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

### rtl/ppt_pkg.sv
// Shared types, widths and codes of the pure pursuit tracker.
// No dependencies; used by every module of the block.
package ppt_pkg;

  localparam int CRD_W  = 32;   // stored coordinate
  localparam int DIF_W  = 33;   // coordinate difference
  localparam int MUL_W  = 33;   // shared multiplier operand
  localparam int PRD_W  = 66;   // shared multiplier product
  localparam int D2_W   = 65;   // squared distance
  localparam int LIM_W  = 25;   // distance register
  localparam int LSQ_W  = 50;   // squared distance register
  localparam int QC_W   = 16;   // quaternion component
  localparam int AMAG_W = 64;   // numerator magnitude
  localparam int DEN_W  = 96;   // d2 * q
  localparam int DIVD_W = 97;   // divisor 2 * d2 * q
  localparam int NUM_W  = 99;   // dividend
  localparam int CURV_W = 32;
  localparam int MODE_W = 8;
  localparam int MIDX_W = 10;   // index fields on the ports

  // item kinds
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_POSE    = 2'd2;
  localparam logic [1:0] KIND_MISSION = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] CFG_JUMP      = 2'd1;
  localparam logic [1:0] CFG_ADVANCE   = 2'd2;
  localparam logic [1:0] CFG_MISSION   = 2'd3;

  // one waypoint table entry
  typedef struct packed {
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [MODE_W-1:0] mode;
  } wp_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic              done;
    logic              big;
    logic [CURV_W-1:0] quo;
  } div_res_t;

  function automatic logic [DIF_W-1:0] mag33(input logic [DIF_W-1:0] v);
    return v[DIF_W-1] ? (~v + DIF_W'(1)) : v;
  endfunction

  function automatic logic [QC_W-1:0] mag16(input logic [QC_W-1:0] v);
    return v[QC_W-1] ? (~v + QC_W'(1)) : v;
  endfunction

endpackage

### rtl/pure_pursuit_tracker_unit.sv
// Pure pursuit tracker top: sequencer, shared 33x33 multiplier, registers.
// Depends on ppt_pkg, ppt_wp_mem, ppt_div and assert_macros.svh.
//
//  channel | direction | handshake              | beat carries
//  in      | input     | in_valid_i / in_stall_o | kind, point, quaternion, mode, index
//  out     | output    | out_valid_o/out_stall_i | curvature, indexes, mode, flags
//  cfg     | input     | cfg_valid_i/cfg_ready_o | register index and 25-bit data
//
// Clear and append go straight to the output state. A mission check reads and
// measures one waypoint. A pose reads, latches, squares and compares each waypoint
// visited by each scan (a nearest search visits all of them, at most two per pose),
// then computes the curvature with the shared multiplier and the 99-step divider.
// Reset is asynchronous, active low; the table needs no clearing pass.
// A stalled result holds the next result in the output state, not the next item.
`include "assert_macros.svh"

module pure_pursuit_tracker_unit #(
  parameter int MAX_WAYPOINTS = 1024,
  parameter int COORD_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [15:0] heading_qz_i,
  input  logic [15:0] heading_qw_i,
  input  logic [7:0]  waypoint_mode_i,
  input  logic [9:0]  mission_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        curvature_valid_o,
  output logic [31:0] curvature_o,
  output logic [9:0]  goal_index_o,
  output logic [9:0]  current_index_o,
  output logic [7:0]  segment_mode_o,
  output logic        mission_reached_o,
  output logic        index_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  localparam int IW    = $clog2(MAX_WAYPOINTS);
  localparam int PLW   = $clog2(MAX_WAYPOINTS + 1);
  localparam int CMPW  = (PLW > ppt_pkg::MIDX_W) ? PLW : ppt_pkg::MIDX_W;
  localparam int CWE   = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int SHC   = 32 - CWE;
  localparam int MULW  = ppt_pkg::MUL_W;
  localparam int D2W   = ppt_pkg::D2_W;
  localparam int LSQW  = ppt_pkg::LSQ_W;
  localparam int DENW  = ppt_pkg::DEN_W;
  localparam int NUMW  = ppt_pkg::NUM_W;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_SQ      = 12'b0000_0000_0010,
    S_RD      = 12'b0000_0000_0100,
    S_LAT     = 12'b0000_0000_1000,
    S_MX      = 12'b0000_0001_0000,
    S_MY      = 12'b0000_0010_0000,
    S_ACT     = 12'b0000_0100_0000,
    S_CUR_CHK = 12'b0000_1000_0000,
    S_TGT_CHK = 12'b0001_0000_0000,
    S_CQ      = 12'b0010_0000_0000,
    S_DIV     = 12'b0100_0000_0000,
    S_OUT     = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    CTX_NEAR1, CTX_NEAR2, CTX_CUR, CTX_TGT, CTX_CURV, CTX_MIS
  } ctx_e;

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;

  logic [PLW-1:0] idx_q, idx_d, plen_q, plen_d;
  logic [IW-1:0]  best_q, best_d, tp_q, tp_d, cp_q, cp_d;
  logic           tv_q, tv_d;
  logic [7:0]     mode_q, mode_d, rmode_q, rmode_d;
  logic [31:0]    px_q, px_d, py_q, py_d;
  logic [15:0]    qz_q, qz_d, qw_q, qw_d;
  logic [24:0]    la_q, jd_q, ad_q, mr_q;
  logic [LSQW-1:0] la2_q, la2_d, jd2_q, jd2_d, ad2_q, ad2_d, mr2_q, mr2_d;
  logic [1:0]     sq_q, sq_d;
  logic [2:0]     cq_q, cq_d;
  logic [32:0]    dx_q, dx_d, dy_q, dy_d;
  logic [D2W-1:0] d2_q, d2_d, bd_q, bd_d;
  logic [31:0]    t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic [63:0]    m1_q, m1_d, m2_q, m2_d, amag_q, amag_d;
  logic           aneg_q, aneg_d;
  logic [DENW-1:0] den_q, den_d;
  logic           wcv_q, wcv_d, wreach_q, wreach_d, werr_q, werr_d;
  logic [31:0]    wcurv_q, wcurv_d;
  logic           ovld_q, ovld_d, ocv_q, ocv_d, oreach_q, oreach_d, oerr_q, oerr_d;
  logic [31:0]    ocurv_q, ocurv_d;
  logic [IW-1:0]  otp_q, otp_d, ocp_q, ocp_d;
  logic [7:0]     omode_q, omode_d;

  logic [MULW-1:0]  mul_a, mul_b;
  logic [ppt_pkg::PRD_W-1:0] mul_p;
  logic             mem_we;
  ppt_pkg::wp_t     wdata, rdata;
  logic             div_start;
  ppt_pkg::div_res_t div_res;
  logic [31:0]      in_x, in_y;
  logic [CMPW-1:0]  m_ext;
  logic signed [32:0] c_s;
  logic [32:0]      c_mag, dx_mag, dy_mag;
  logic [31:0]      q_sum, q_eff;
  logic             s2_neg, sa, sb;

  function automatic logic [9:0] m_ext_out(input logic [IW-1:0] v);
    logic [CMPW-1:0] w;
    w = CMPW'(v);
    return w[9:0];
  endfunction

  // sign-extend the low coordinate bits
  assign in_x  = 32'($signed(point_x_i << SHC) >>> SHC);
  assign in_y  = 32'($signed(point_y_i << SHC) >>> SHC);
  assign m_ext = CMPW'(mission_index_i);

  // heading terms from qz^2, qw^2 and |qz*qw|
  assign c_s    = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
  assign c_mag  = ppt_pkg::mag33(c_s);
  assign dx_mag = ppt_pkg::mag33(dx_q);
  assign dy_mag = ppt_pkg::mag33(dy_q);
  assign q_sum  = t0_q + t1_q;
  assign q_eff  = (q_sum == 32'd0) ? 32'd1 : q_sum;
  assign s2_neg = (qz_q[15] != qw_q[15]) && (t2_q != 32'd0);
  assign sa     = c_s[32] != dy_q[32];
  assign sb     = !(s2_neg != dx_q[32]);

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  assign wdata.x    = in_x;
  assign wdata.y    = in_y;
  assign wdata.mode = waypoint_mode_i;

  ppt_wp_mem #(
    .DEPTH (MAX_WAYPOINTS),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (plen_q[IW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rdata)
  );

  ppt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ((NUMW'(amag_q) << 34) + NUMW'(den_q)),
    .den_i   (ppt_pkg::DIVD_W'(den_q) << 1),
    .res_o   (div_res)
  );

  // sequencer
  always_comb begin
    logic [IW-1:0] nb;
    nb        = best_q;
    state_d   = state_q;
    ctx_d     = ctx_q;
    idx_d     = idx_q;
    plen_d    = plen_q;
    best_d    = best_q;
    bd_d      = bd_q;
    tp_d      = tp_q;
    cp_d      = cp_q;
    tv_d      = tv_q;
    mode_d    = mode_q;
    rmode_d   = rmode_q;
    px_d      = px_q;
    py_d      = py_q;
    qz_d      = qz_q;
    qw_d      = qw_q;
    la2_d     = la2_q;
    jd2_d     = jd2_q;
    ad2_d     = ad2_q;
    mr2_d     = mr2_q;
    sq_d      = sq_q;
    cq_d      = cq_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    d2_d      = d2_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    m1_d      = m1_q;
    m2_d      = m2_q;
    amag_d    = amag_q;
    aneg_d    = aneg_q;
    den_d     = den_q;
    wcv_d     = wcv_q;
    wcurv_d   = wcurv_q;
    wreach_d  = wreach_q;
    werr_d    = werr_q;
    ovld_d    = ovld_q && out_stall_i;
    ocv_d     = ocv_q;
    ocurv_d   = ocurv_q;
    otp_d     = otp_q;
    ocp_d     = ocp_q;
    omode_d   = omode_q;
    oreach_d  = oreach_q;
    oerr_d    = oerr_q;
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    div_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          wcv_d    = 1'b0;
          wcurv_d  = '0;
          wreach_d = 1'b0;
          werr_d   = 1'b0;
          state_d  = S_OUT;
          case (kind_i)
            ppt_pkg::KIND_CLEAR: begin
              plen_d = '0;
              tv_d   = 1'b0;
            end
            ppt_pkg::KIND_APPEND: begin
              if (plen_q == PLW'(MAX_WAYPOINTS)) begin
                werr_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                plen_d = plen_q + PLW'(1);
                tv_d   = 1'b0;
              end
            end
            ppt_pkg::KIND_POSE: begin
              px_d = in_x;
              py_d = in_y;
              qz_d = heading_qz_i;
              qw_d = heading_qw_i;
              if (plen_q == '0) begin
                tv_d = 1'b0;
              end else begin
                sq_d    = 2'd0;
                state_d = S_SQ;
              end
            end
            ppt_pkg::KIND_MISSION: begin
              if (m_ext >= CMPW'(plen_q)) begin
                werr_d = 1'b1;
              end else begin
                idx_d   = PLW'(m_ext[IW-1:0]);
                sq_d    = 2'd3;
                state_d = S_SQ;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      // square the distance registers
      S_SQ: begin
        case (sq_q)
          2'd0: begin
            mul_a = MULW'(la_q);
            mul_b = MULW'(la_q);
            la2_d = mul_p[LSQW-1:0];
          end
          2'd1: begin
            mul_a = MULW'(jd_q);
            mul_b = MULW'(jd_q);
            jd2_d = mul_p[LSQW-1:0];
          end
          2'd2: begin
            mul_a = MULW'(ad_q);
            mul_b = MULW'(ad_q);
            ad2_d = mul_p[LSQW-1:0];
          end
          default: begin
            mul_a = MULW'(mr_q);
            mul_b = MULW'(mr_q);
            mr2_d = mul_p[LSQW-1:0];
          end
        endcase
        sq_d = sq_q + 2'd1;
        if (sq_q == 2'd3) begin
          ctx_d   = CTX_MIS;
          state_d = S_RD;
        end else if (sq_q == 2'd2) begin
          if (!tv_q) begin
            ctx_d   = CTX_NEAR1;
            idx_d   = '0;
            state_d = S_RD;
          end else begin
            idx_d   = PLW'(cp_q);
            state_d = S_CUR_CHK;
          end
        end
      end

      S_RD: begin
        state_d = S_LAT;
      end

      // latch differences to the pose
      S_LAT: begin
        dx_d    = 33'($signed({rdata.x[31], rdata.x}) - $signed({px_q[31], px_q}));
        dy_d    = 33'($signed({rdata.y[31], rdata.y}) - $signed({py_q[31], py_q}));
        rmode_d = rdata.mode;
        state_d = S_MX;
      end

      S_MX: begin
        mul_a   = dx_mag;
        mul_b   = dx_mag;
        d2_d    = mul_p[D2W-1:0];
        state_d = S_MY;
      end

      S_MY: begin
        mul_a   = dy_mag;
        mul_b   = dy_mag;
        d2_d    = d2_q + mul_p[D2W-1:0];
        state_d = S_ACT;
      end

      // use the distance according to the scan in progress
      S_ACT: begin
        case (ctx_q)
          CTX_NEAR1, CTX_NEAR2: begin
            if (idx_q == '0 || d2_q < bd_q) begin
              bd_d = d2_q;
              nb   = idx_q[IW-1:0];
            end
            best_d = nb;
            if (idx_q + PLW'(1) == plen_q) begin
              if (ctx_q == CTX_NEAR1) begin
                tp_d    = nb;
                cp_d    = nb;
                idx_d   = PLW'(nb);
                state_d = S_CUR_CHK;
              end else begin
                cp_d    = nb;
                tv_d    = 1'b0;
                idx_d   = PLW'(tp_q);
                state_d = S_TGT_CHK;
              end
            end else begin
              idx_d   = idx_q + PLW'(1);
              state_d = S_RD;
            end
          end
          CTX_CUR: begin
            if (d2_q > D2W'(jd2_q)) begin
              ctx_d   = CTX_NEAR2;
              idx_d   = '0;
              state_d = S_RD;
            end else if (d2_q > D2W'(ad2_q)) begin
              cp_d    = idx_q[IW-1:0];
              mode_d  = rmode_q;
              tv_d    = 1'b0;
              idx_d   = PLW'(tp_q);
              state_d = S_TGT_CHK;
            end else begin
              idx_d   = idx_q + PLW'(1);
              state_d = S_CUR_CHK;
            end
          end
          CTX_TGT: begin
            if (d2_q > D2W'(la2_q)) begin
              tp_d  = idx_q[IW-1:0];
              tv_d  = 1'b1;
              ctx_d = CTX_CURV;
            end else begin
              idx_d   = idx_q + PLW'(1);
              state_d = S_TGT_CHK;
            end
          end
          CTX_CURV: begin
            wcv_d = 1'b1;
            if (d2_q == '0) begin
              wcurv_d = '0;
              state_d = S_OUT;
            end else begin
              cq_d    = 3'd0;
              state_d = S_CQ;
            end
          end
          CTX_MIS: begin
            wreach_d = d2_q < D2W'(mr2_q);
            state_d  = S_OUT;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end

      // advance the current pointer
      S_CUR_CHK: begin
        if (idx_q >= plen_q) begin
          tv_d    = 1'b0;
          idx_d   = PLW'(tp_q);
          state_d = S_TGT_CHK;
        end else if (idx_q == plen_q - PLW'(1)) begin
          cp_d    = idx_q[IW-1:0];
          tv_d    = 1'b0;
          idx_d   = PLW'(tp_q);
          state_d = S_TGT_CHK;
        end else begin
          ctx_d   = CTX_CUR;
          state_d = S_RD;
        end
      end

      // advance the target pointer
      S_TGT_CHK: begin
        if (idx_q >= plen_q) begin
          state_d = S_OUT;
        end else if (idx_q == plen_q - PLW'(1)) begin
          tp_d    = idx_q[IW-1:0];
          tv_d    = 1'b1;
          ctx_d   = CTX_CURV;
          state_d = S_RD;
        end else begin
          ctx_d   = CTX_TGT;
          state_d = S_RD;
        end
      end

      // curvature numerator and denominator
      S_CQ: begin
        cq_d = cq_q + 3'd1;
        case (cq_q)
          3'd0: begin
            mul_a = MULW'(ppt_pkg::mag16(qz_q));
            mul_b = MULW'(ppt_pkg::mag16(qz_q));
            t0_d  = mul_p[31:0];
          end
          3'd1: begin
            mul_a = MULW'(ppt_pkg::mag16(qw_q));
            mul_b = MULW'(ppt_pkg::mag16(qw_q));
            t1_d  = mul_p[31:0];
          end
          3'd2: begin
            mul_a = MULW'(ppt_pkg::mag16(qz_q));
            mul_b = MULW'(ppt_pkg::mag16(qw_q));
            t2_d  = mul_p[31:0];
          end
          3'd3: begin
            mul_a = c_mag;
            mul_b = dy_mag;
            m2_d  = mul_p[63:0];
          end
          3'd4: begin
            mul_a = MULW'({t2_q[30:0], 1'b0});
            mul_b = dx_mag;
            m1_d  = mul_p[63:0];
          end
          3'd5: begin
            if (q_sum == 32'd0) begin
              amag_d = 64'(dy_mag);
              aneg_d = dy_q[32];
            end else if (sa == sb) begin
              amag_d = m1_q + m2_q;
              aneg_d = sa;
            end else if (m2_q >= m1_q) begin
              amag_d = m2_q - m1_q;
              aneg_d = sa;
            end else begin
              amag_d = m1_q - m2_q;
              aneg_d = sb;
            end
            mul_a = d2_q[32:0];
            mul_b = MULW'(q_eff);
            den_d = DENW'(mul_p);
          end
          3'd6: begin
            mul_a = MULW'(d2_q[D2W-1:33]);
            mul_b = MULW'(q_eff);
            den_d = den_q + (DENW'(mul_p) << 33);
          end
          default: begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        endcase
      end

      // sign and saturate the rounded quotient
      S_DIV: begin
        if (div_res.done) begin
          if (aneg_q) begin
            wcurv_d = div_res.big ? 32'h8000_0000 : (32'd0 - div_res.quo);
          end else begin
            wcurv_d = div_res.big ? 32'h7FFF_FFFF : div_res.quo;
          end
          state_d = S_OUT;
        end
      end

      // load the result once the output register is free
      S_OUT: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d   = 1'b1;
          ocv_d    = wcv_q;
          ocurv_d  = wcurv_q;
          otp_d    = tp_q;
          ocp_d    = cp_q;
          omode_d  = mode_q;
          oreach_d = wreach_q;
          oerr_d   = werr_q;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ctx_q   <= CTX_NEAR1;
      plen_q  <= '0;
      tv_q    <= 1'b0;
      tp_q    <= '0;
      cp_q    <= '0;
      mode_q  <= '0;
      px_q    <= '0;
      py_q    <= '0;
      qz_q    <= '0;
      qw_q    <= '0;
      sq_q    <= '0;
      cq_q    <= '0;
      ovld_q  <= 1'b0;
      la_q    <= 25'd0;
      jd_q    <= 25'd262144;
      ad_q    <= 25'd65536;
      mr_q    <= 25'd52429;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
      plen_q  <= plen_d;
      tv_q    <= tv_d;
      tp_q    <= tp_d;
      cp_q    <= cp_d;
      mode_q  <= mode_d;
      px_q    <= px_d;
      py_q    <= py_d;
      qz_q    <= qz_d;
      qw_q    <= qw_d;
      sq_q    <= sq_d;
      cq_q    <= cq_d;
      ovld_q  <= ovld_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ppt_pkg::CFG_LOOKAHEAD: la_q <= cfg_data_i;
          ppt_pkg::CFG_JUMP:      jd_q <= cfg_data_i;
          ppt_pkg::CFG_ADVANCE:   ad_q <= cfg_data_i;
          ppt_pkg::CFG_MISSION:   mr_q <= cfg_data_i;
          default:                la_q <= la_q;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    best_q   <= best_d;
    bd_q     <= bd_d;
    rmode_q  <= rmode_d;
    la2_q    <= la2_d;
    jd2_q    <= jd2_d;
    ad2_q    <= ad2_d;
    mr2_q    <= mr2_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    d2_q     <= d2_d;
    t0_q     <= t0_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    amag_q   <= amag_d;
    aneg_q   <= aneg_d;
    den_q    <= den_d;
    wcv_q    <= wcv_d;
    wcurv_q  <= wcurv_d;
    wreach_q <= wreach_d;
    werr_q   <= werr_d;
    ocv_q    <= ocv_d;
    ocurv_q  <= ocurv_d;
    otp_q    <= otp_d;
    ocp_q    <= ocp_d;
    omode_q  <= omode_d;
    oreach_q <= oreach_d;
    oerr_q   <= oerr_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = ovld_q;
  assign curvature_valid_o = ocv_q;
  assign curvature_o       = ocurv_q;
  assign goal_index_o      = m_ext_out(otp_q);
  assign current_index_o   = m_ext_out(ocp_q);
  assign segment_mode_o    = omode_q;
  assign mission_reached_o = oreach_q;
  assign index_error_o     = oerr_q;

  `PP_ASSERT(a_plen_bound, plen_q <= PLW'(MAX_WAYPOINTS), "path length beyond table")
  `PP_ASSERT(a_ptr_in_path, (state_q == S_IDLE && tv_q) |-> (PLW'(tp_q) < plen_q && PLW'(cp_q) < plen_q), "pointer outside path")
  `PP_ASSERT(a_div_in_state, div_res.done |-> (state_q == S_DIV), "divider done outside divide")
  `PP_NEVER(a_curv_clean, out_valid_o && curvature_valid_o && (index_error_o || mission_reached_o), "curvature beat with flags")

endmodule

### rtl/ppt_wp_mem.sv
// Waypoint table: one write port, one registered read port.
// Depends on ppt_pkg for the entry type.
module ppt_wp_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  ppt_pkg::wp_t   wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output ppt_pkg::wp_t   rdata_o
);

  ppt_pkg::wp_t mem_q [DEPTH];
  ppt_pkg::wp_t rdata_q;

  // write on append, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ppt_div.sv
// Restoring divider, one quotient bit per cycle, saturation flag on top.
// Depends on ppt_pkg for widths and the result struct.
module ppt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppt_pkg::NUM_W-1:0]  num_i,
  input  logic [ppt_pkg::DIVD_W-1:0] den_i,
  output ppt_pkg::div_res_t          res_o
);

  localparam int CW = $clog2(ppt_pkg::NUM_W + 1);

  logic [ppt_pkg::NUM_W-1:0]  n_q;
  logic [ppt_pkg::DIVD_W-1:0] d_q, r_q;
  logic [ppt_pkg::CURV_W-1:0] quo_q;
  logic                       big_q, busy_q, done_q;
  logic [CW-1:0]              cnt_q;
  logic [ppt_pkg::DIVD_W:0]   rsh, rsub;
  logic                       ge;

  // shift in next dividend bit, trial subtract
  assign rsh  = {r_q, n_q[ppt_pkg::NUM_W-1]};
  assign ge   = rsh >= {1'b0, d_q};
  assign rsub = rsh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ppt_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      r_q   <= '0;
      quo_q <= '0;
      big_q <= 1'b0;
    end else if (busy_q) begin
      n_q   <= {n_q[ppt_pkg::NUM_W-2:0], 1'b0};
      r_q   <= ge ? rsub[ppt_pkg::DIVD_W-1:0] : rsh[ppt_pkg::DIVD_W-1:0];
      quo_q <= {quo_q[ppt_pkg::CURV_W-2:0], ge};
      big_q <= big_q | quo_q[ppt_pkg::CURV_W-1];
    end
  end

  assign res_o.done = done_q;
  assign res_o.big  = big_q | quo_q[ppt_pkg::CURV_W-1];
  assign res_o.quo  = quo_q;

endmodule

### bench/pure_pursuit_tracker_unit_tb.sv
// Self-checking bench for the pure pursuit tracker: directed items, then random paths.
// Depends on ppt_pkg and pure_pursuit_tracker_unit; predicts every result beat inline.
module pure_pursuit_tracker_unit_tb;

  localparam int NWP   = 1024;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] x, y;
    logic [15:0] qz, qw;
    logic [7:0]  mode;
    logic [9:0]  midx;
  } item_t;

  typedef struct {
    logic        cv;
    logic [31:0] curv;
    logic [9:0]  tgt, cur;
    logic [7:0]  mode;
    logic        reached, err;
  } steer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0]  kind_i = ppt_pkg::KIND_CLEAR;
  logic [31:0] point_x_i = '0, point_y_i = '0;
  logic [15:0] heading_qz_i = '0, heading_qw_i = '0;
  logic [7:0]  waypoint_mode_i = '0;
  logic [9:0]  mission_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic curvature_valid_o;
  logic [31:0] curvature_o;
  logic [9:0]  goal_index_o, current_index_o;
  logic [7:0]  segment_mode_o;
  logic mission_reached_o, index_error_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0]  cfg_index_i = ppt_pkg::CFG_LOOKAHEAD;
  logic [24:0] cfg_data_i = '0;

  pure_pursuit_tracker_unit uut (.*);

  // tracker state as predicted
  longint     wp_x [NWP];
  longint     wp_y [NWP];
  logic [7:0] wp_md [NWP];
  int         n_wp;
  bit         aim_ok;
  int         aim_idx, at_idx;
  logic [7:0] seg_md;
  longint     pose_x, pose_y, pose_qz, pose_qw;
  logic [24:0] r_look, r_jump, r_adv, r_miss;

  item_t  pend_items [$];
  steer_t steer_q [$];
  item_t  held;
  int     in_gap, out_gap, hold_cnt, errors;
  int     cycles = 0;
  bit     hold_go, hold_done, calm;
  longint path_px [$];
  longint path_py [$];

  initial forever #2 clk_i = ~clk_i;

  function automatic logic [127:0] dist_sq(int i);
    longint dx, dy;
    logic [63:0] ax, ay;
    dx = wp_x[i] - pose_x;
    dy = wp_y[i] - pose_y;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    return {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
  endfunction

  function automatic bit beyond(logic [127:0] d2, logic [24:0] lim);
    return d2 > ({103'd0, lim} * {103'd0, lim});
  endfunction

  function automatic int nearest_wp();
    int best;
    logic [127:0] bd, d;
    best = 0;
    bd = dist_sq(0);
    for (int i = 1; i < n_wp; i++) begin
      d = dist_sq(i);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    return best;
  endfunction

  // curvature 2*rel_y/d^2 toward waypoint t, rounded half away, saturated
  function automatic logic [31:0] steer_curv(int t);
    longint dx, dy, q, c, s2;
    logic [63:0] amag, m1, m2, adx, ady, ac, as2;
    logic [255:0] d2, den, num, quo;
    bit aneg, sa, sb;
    dx = wp_x[t] - pose_x;
    dy = wp_y[t] - pose_y;
    q = pose_qz * pose_qz + pose_qw * pose_qw;
    d2 = {128'd0, dist_sq(t)};
    if (d2 == 0) return '0;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (q == 0) begin
      q = 1;
      amag = ady;
      aneg = dy < 0;
    end else begin
      c = pose_qw * pose_qw - pose_qz * pose_qz;
      s2 = 2 * pose_qz * pose_qw;
      ac = c < 0 ? -c : c;
      as2 = s2 < 0 ? -s2 : s2;
      m2 = ac * ady;
      m1 = as2 * adx;
      sa = (c < 0) != (dy < 0);
      sb = !((s2 < 0) != (dx < 0));
      if (sa == sb) begin
        amag = m1 + m2;
        aneg = sa;
      end else if (m2 >= m1) begin
        amag = m2 - m1;
        aneg = sa;
      end else begin
        amag = m1 - m2;
        aneg = sb;
      end
    end
    den = d2 * {192'd0, 64'(q)};
    num = ({192'd0, amag} << 34) + den;
    quo = num / (den << 1);
    if (aneg) begin
      if (quo >= 256'h8000_0000) return 32'h8000_0000;
      return 32'd0 - quo[31:0];
    end
    if (quo > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  // advance the predicted state by one accepted beat and queue its result
  task automatic track_item(item_t it);
    steer_t r;
    logic [127:0] d;
    r = '{default: '0};
    case (it.kind)
      ppt_pkg::KIND_CLEAR: begin
        n_wp = 0;
        aim_ok = 0;
      end
      ppt_pkg::KIND_APPEND: begin
        if (n_wp >= NWP) r.err = 1;
        else begin
          wp_x[n_wp] = longint'(signed'(it.x));
          wp_y[n_wp] = longint'(signed'(it.y));
          wp_md[n_wp] = it.mode;
          n_wp++;
          aim_ok = 0;
        end
      end
      ppt_pkg::KIND_POSE: begin
        pose_x = longint'(signed'(it.x));
        pose_y = longint'(signed'(it.y));
        pose_qz = longint'(signed'(it.qz));
        pose_qw = longint'(signed'(it.qw));
        if (n_wp == 0) aim_ok = 0;
        else begin
          if (!aim_ok) begin
            aim_idx = nearest_wp();
            at_idx = aim_idx;
          end
          for (int i = at_idx; i < n_wp; i++) begin
            if (i == n_wp - 1) begin
              at_idx = i;
              break;
            end
            d = dist_sq(i);
            if (beyond(d, r_jump)) begin
              at_idx = nearest_wp();
              break;
            end
            if (beyond(d, r_adv)) begin
              at_idx = i;
              seg_md = wp_md[i];
              break;
            end
          end
          aim_ok = 0;
          for (int i = aim_idx; i < n_wp; i++) begin
            if (i == n_wp - 1 || beyond(dist_sq(i), r_look)) begin
              aim_idx = i;
              aim_ok = 1;
              break;
            end
          end
          if (aim_ok) begin
            r.cv = 1;
            r.curv = steer_curv(aim_idx);
          end
        end
      end
      default: begin
        if (int'(it.midx) >= n_wp) r.err = 1;
        else r.reached = dist_sq(it.midx) < ({103'd0, r_miss} * {103'd0, r_miss});
      end
    endcase
    r.tgt = 10'(aim_idx);
    r.cur = 10'(at_idx);
    r.mode = seg_md;
    steer_q.push_back(r);
  endtask

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("  %s: expected %0h, got %0h at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  // driver: present pending beats, hold them while stalled, idle in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) track_item(held);
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pend_items.size() > 0) begin
          held = pend_items.pop_front();
          kind_i <= held.kind;
          point_x_i <= held.x;
          point_y_i <= held.y;
          heading_qz_i <= held.qz;
          heading_qw_i <= held.qw;
          waypoint_mode_i <= held.mode;
          mission_index_i <= held.midx;
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt <= 600;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : mon
    steer_t e;
    bit burst;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (steer_q.size() == 0) begin
          $display("  result beat with nothing predicted at cycle %0d", cycles);
          errors++;
        end else begin
          e = steer_q.pop_front();
          if (curvature_valid_o !== e.cv) report("curvature_valid", e.cv, curvature_valid_o);
          if (curvature_o !== e.curv) report("curvature", e.curv, curvature_o);
          if (goal_index_o !== e.tgt) report("goal_index", e.tgt, goal_index_o);
          if (current_index_o !== e.cur) report("current_index", e.cur, current_index_o);
          if (segment_mode_o !== e.mode) report("segment_mode", e.mode, segment_mode_o);
          if (mission_reached_o !== e.reached)
            report("mission_reached", e.reached, mission_reached_o);
          if (index_error_o !== e.err) report("index_error", e.err, index_error_o);
        end
      end
      burst = 0;
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        burst = 1;
      end else if (!calm && $urandom_range(0, 12) == 0) begin
        out_gap <= $urandom_range(0, 10);
        burst = 1;
      end
      out_stall_i <= burst || hold_cnt != 0;
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push(logic [1:0] k, logic [31:0] x, logic [31:0] y, logic [31:0] qz,
                      logic [31:0] qw, logic [31:0] md, logic [31:0] mi);
    item_t it;
    it = '{kind: k, x: x, y: y, qz: qz[15:0], qw: qw[15:0], mode: md[7:0],
           midx: mi[9:0]};
    pend_items.push_back(it);
  endtask

  function automatic int jitter(int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  task automatic drain();
    do @(posedge clk_i); while (pend_items.size() != 0 || in_valid_i || steer_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // write all four distance registers back to back, then drop valid
  task automatic set_radii(logic [24:0] la, logic [24:0] jp, logic [24:0] ad,
                           logic [24:0] mr);
    logic [24:0] v [4];
    v = '{la, jp, ad, mr};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i <= v[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (2'(i))
        ppt_pkg::CFG_LOOKAHEAD: r_look = v[i];
        ppt_pkg::CFG_JUMP:      r_jump = v[i];
        ppt_pkg::CFG_ADVANCE:   r_adv = v[i];
        default:                r_miss = v[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // a path with random content, then a walk along it with mission checks and noise
  task automatic track_run(int npts, int nitems);
    int x0, y0, k, sel, idx;
    x0 = jitter(1 << 22);
    y0 = jitter(1 << 22);
    path_px.delete();
    path_py.delete();
    push(ppt_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < npts; i++) begin
      path_px.push_back(x0 + i * 40000 + jitter(8000));
      path_py.push_back(y0 + i * jitter(20000) + jitter(8000));
      push(ppt_pkg::KIND_APPEND, 32'(path_px[i]), 32'(path_py[i]), $urandom, $urandom,
           $urandom, $urandom);
    end
    k = 0;
    for (int n = 0; n < nitems; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) k = $urandom_range(0, npts - 1);
      else if ($urandom_range(0, 2) != 0 && k < npts - 1) k++;
      idx = k;
      if (sel < 65) begin
        push(ppt_pkg::KIND_POSE, 32'(path_px[idx] + jitter(20000)),
             32'(path_py[idx] + jitter(20000)),
             32'(jitter(32768)), 32'(jitter(32768)), $urandom, $urandom);
      end else if (sel < 85) begin
        push(ppt_pkg::KIND_MISSION, $urandom, $urandom, $urandom, $urandom, $urandom,
             32'($urandom_range(0, npts + 2)));
      end else if (sel < 92) begin
        push(ppt_pkg::KIND_APPEND, 32'(path_px[npts - 1] + 40000), 32'(path_py[npts - 1]),
             $urandom, $urandom, $urandom, $urandom);
      end else begin
        push(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    n_wp = 0;
    aim_ok = 0;
    aim_idx = 0;
    at_idx = 0;
    seg_md = '0;
    pose_x = 0;
    pose_y = 0;
    pose_qz = 0;
    pose_qw = 0;
    r_look = 25'd0;
    r_jump = 25'd262144;
    r_adv = 25'd65536;
    r_miss = 25'd52429;
    errors = 0;
    hold_go = 0;
    calm = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, zero quaternion, ties, zero distance
    push(ppt_pkg::KIND_MISSION, 0, 0, 0, 0, 0, 32'd0);
    push(ppt_pkg::KIND_POSE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF, 32'h8000, 0, 0);
    push(ppt_pkg::KIND_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'hFF, 0);
    push(ppt_pkg::KIND_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h00, 0);
    push(ppt_pkg::KIND_POSE, 0, 0, 32'h0000, 32'h0000, 0, 0);
    push(ppt_pkg::KIND_POSE, 32'h8000_0000, 32'h8000_0000, 32'h8000, 32'h7FFF, 0, 0);
    push(ppt_pkg::KIND_MISSION, 0, 0, 0, 0, 0, 32'd1);
    push(ppt_pkg::KIND_MISSION, 0, 0, 0, 0, 0, 32'd1023);
    push(ppt_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0);
    push(ppt_pkg::KIND_APPEND, 32'h0001_0000, 0, 0, 0, 32'h5A, 0);
    push(ppt_pkg::KIND_APPEND, 32'hFFFF_0000, 0, 0, 0, 32'hA5, 0);
    push(ppt_pkg::KIND_APPEND, 0, 32'h0003_0000, 0, 0, 32'h3C, 0);
    push(ppt_pkg::KIND_APPEND, 0, 32'h0006_0000, 0, 0, 32'hC3, 0);
    push(ppt_pkg::KIND_POSE, 0, 0, 32'h0000, 32'h7FFF, 0, 0);
    push(ppt_pkg::KIND_POSE, 0, 32'h0003_0000, 32'h5A82, 32'h5A82, 0, 0);
    push(ppt_pkg::KIND_POSE, 0, 32'h0006_0000, 32'h8000, 32'h0000, 0, 0);
    push(ppt_pkg::KIND_MISSION, 0, 0, 0, 0, 0, 32'd3);
    push(ppt_pkg::KIND_MISSION, 0, 0, 0, 0, 0, 32'd2);
    push(ppt_pkg::KIND_MISSION, 0, 0, 0, 0, 0, 32'd4);
    push(ppt_pkg::KIND_POSE, 32'h0020_0000, 32'hFFE0_0000, 32'h1234, 32'hEDCB, 0, 0);
    push(ppt_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0);
    push(ppt_pkg::KIND_POSE, 0, 0, 0, 0, 0, 0);
    drain();

    // several settings of the distance registers, extremes among them
    set_radii(25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216);
    track_run(6, 30);
    drain();
    set_radii(25'd0, 25'd0, 25'd0, 25'd0);
    hold_go = 1;
    track_run(12, 40);
    drain();
    set_radii(25'd98304, 25'd196608, 25'd32768, 25'd65536);
    track_run(20, 45);
    drain();

    set_radii(25'd65536, 25'd262144, 25'd65536, 25'd52429);
    track_run(15, 45);
    drain();

    // last stretch without idling on either side
    calm = 1;
    set_radii(25'($urandom_range(0, 150000)), 25'($urandom_range(0, 400000)),
              25'($urandom_range(0, 90000)), 25'($urandom_range(0, 90000)));
    track_run(10, 40);
    drain();
    repeat (200) @(posedge clk_i);

    if (steer_q.size() != 0) begin
      $display("  %0d predicted results never arrived", steer_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
